>>> design/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

    // Thread count; numbers beyond 15 cannot be carried, so above 16 acts as 16
    localparam int NumThreads = 16;
    localparam int EffThreads = (NumThreads >= 16) ? 16 : NumThreads;

    // Bit per thread that is present
    localparam logic [15:0] PresentMask = 16'((33'd1 << EffThreads) - 33'd1);

    // One scheduling point as held in the input register
    typedef struct packed {
        logic [3:0]  last_thread;
        logic [15:0] enabled_mask;
        logic        is_yield;
    } t_sched_item;

    // One scheduling decision
    typedef struct packed {
        logic [3:0]  chosen_thread;
        logic        chosen_valid;
        logic [15:0] fair_mask;
    } t_sched_result;

endpackage

`default_nettype wire

>>> design/fts_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fts_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_advance,
    input  wire fts_pkg::t_sched_item i_item,
    output logic [15:0]               o_fair_mask
);

    // Per-thread window sets and priority matrix
    logic [15:0] r_esy [16];
    logic [15:0] r_dsy [16];
    logic [15:0] r_ssy [16];
    logic [15:0] r_pri [16];
    logic [15:0] r_prev_en;

    logic [15:0] n_esy [16];
    logic [15:0] n_dsy [16];
    logic [15:0] n_ssy [16];
    logic [15:0] n_pri [16];

    logic [3:0]  t;
    logic [15:0] en;
    logic [15:0] tbit;
    logic        t_present;
    logic [15:0] esy_t;
    logic [15:0] dsy_t;
    logic [15:0] ssy_t;
    logic [15:0] gain;
    logic [15:0] blocked;

    assign t         = i_item.last_thread;
    assign en        = i_item.enabled_mask & fts_pkg::PresentMask;
    assign tbit      = 16'd1 << t;
    assign t_present = |(fts_pkg::PresentMask & tbit);

    // Last thread's rows after the step update, before a yield resets them
    always_comb begin
        esy_t = r_esy[t];
        dsy_t = r_dsy[t];
        ssy_t = r_ssy[t];
        if (t_present) begin
            esy_t = r_esy[t] & en;
            dsy_t = r_dsy[t] | (r_prev_en & ~en);
            ssy_t = r_ssy[t] | tbit;
        end
        gain = (esy_t | dsy_t) & ~ssy_t;
    end

    // Row updates, all threads in parallel
    always_comb begin
        for (int u = 0; u < 16; u++) begin
            n_esy[u] = r_esy[u];
            n_dsy[u] = r_dsy[u];
            n_ssy[u] = r_ssy[u];
            if (fts_pkg::PresentMask[u]) begin
                n_esy[u] = r_esy[u] & en;
                n_ssy[u] = r_ssy[u] | tbit;
                if (4'(u) == t) begin
                    n_dsy[u] = r_dsy[u] | (r_prev_en & ~en);
                end
            end
            if (i_item.is_yield && (4'(u) == t)) begin
                n_esy[u] = en;
                n_dsy[u] = '0;
                n_ssy[u] = '0;
            end
            n_pri[u] = (4'(u) == t) ? 16'd0 : r_pri[u];
            if (i_item.is_yield && gain[u]) begin
                n_pri[u] = n_pri[u] | tbit;
            end
        end
    end

    // Threads blocked by some enabled thread with priority over them
    always_comb begin
        blocked = '0;
        for (int u = 0; u < 16; u++) begin
            if (en[u]) begin
                blocked = blocked | n_pri[u];
            end
        end
        o_fair_mask = en & ~blocked;
    end

    // State commits when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < 16; u++) begin
                r_esy[u] <= '0;
                r_dsy[u] <= '0;
                r_ssy[u] <= '0;
                r_pri[u] <= '0;
            end
            r_prev_en <= '0;
        end else if (i_advance) begin
            for (int u = 0; u < 16; u++) begin
                r_esy[u] <= n_esy[u];
                r_dsy[u] <= n_dsy[u];
                r_ssy[u] <= n_ssy[u];
                r_pri[u] <= n_pri[u];
            end
            r_prev_en <= en;
        end
    end

endmodule

`default_nettype wire

>>> design/fts_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module fts_pick (
    input  wire [3:0]              i_last_thread,
    input  wire [15:0]             i_fair_mask,
    output fts_pkg::t_sched_result o_result
);

    logic [3:0] low_idx;
    logic       any_fair;

    // Lowest fair-enabled thread
    always_comb begin
        low_idx  = '0;
        any_fair = |i_fair_mask;
        for (int u = 15; u >= 0; u--) begin
            if (i_fair_mask[u]) begin
                low_idx = 4'(u);
            end
        end
    end

    // Keep the last thread when it is still fair-enabled
    always_comb begin
        o_result.fair_mask    = i_fair_mask;
        o_result.chosen_valid = any_fair;
        if (i_fair_mask[i_last_thread]) begin
            o_result.chosen_thread = i_last_thread;
        end else begin
            o_result.chosen_thread = low_idx;
        end
    end

endmodule

`default_nettype wire

>>> design/fair_thread_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat is held in the input register, then in the result register.
// Throughput: one scheduling point per cycle unless the result stalls; the window
// sets and priority matrix update in one pass between input and result registers.
// Reset: synchronous, active low; clears all per-thread sets, the priority
// matrix, the previous enabled mask and both valid flags.
module fair_thread_scheduler (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [3:0]  i_last_thread,
    input  wire [15:0] i_enabled_mask,
    input  wire        i_is_yield,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [3:0] o_chosen_thread,
    output logic       o_chosen_valid,
    output logic [15:0] o_fair_mask
);

    fts_pkg::t_sched_item   r_item;
    logic                   r_in_valid;
    fts_pkg::t_sched_result r_result;
    logic                   r_out_valid;

    logic                   advance;
    logic [15:0]            fair_mask;
    fts_pkg::t_sched_result pick_result;

    // Input register moves on when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.last_thread  <= i_last_thread;
            r_item.enabled_mask <= i_enabled_mask;
            r_item.is_yield     <= i_is_yield;
        end
    end

    fts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (r_item),
        .o_fair_mask (fair_mask)
    );

    fts_pick u_pick (
        .i_last_thread (r_item.last_thread),
        .i_fair_mask   (fair_mask),
        .o_result      (pick_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= pick_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_thread = r_result.chosen_thread;
    assign o_chosen_valid  = r_result.chosen_valid;
    assign o_fair_mask     = r_result.fair_mask;

`ifndef SYNTH
    // Chosen flag agrees with the fair mask
    a_valid_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.chosen_valid == (|r_result.fair_mask)))
        else $error("chosen_valid disagrees with fair_mask");

    // A chosen thread is fair-enabled
    a_chosen_is_fair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.chosen_valid) |-> r_result.fair_mask[r_result.chosen_thread])
        else $error("chosen thread not fair-enabled");

    // No choice reports thread zero
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.chosen_valid) |-> (r_result.chosen_thread == 4'd0))
        else $error("chosen_thread nonzero with no choice");

    // A stalled result beat stays valid and unchanged, also while a new item waits in the input register
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
